[design/assert_macros.svh]
// Assertion macros shared by the list unit.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that, once true, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition that, when true, must be matched by another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/iiel_pkg.sv]
// Shared types, sizes and conversion functions for the indexed list unit.
// Used by the cell, the command decoder and the top level.
package iiel_pkg;

    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast from the decoder to every cell of the row.
    typedef struct packed {
        logic             ins_en;
        logic             era_en;
        logic             rd_en;
        logic [IDX_W-1:0] pos;
        logic [WIDTH-1:0] word;
    } cell_bcast_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count_next;
    } dec_result_t;

    function automatic logic [WIDTH-1:0] value_to_word(input logic [31:0] v);
        logic [WIDTH+31:0] tmp;
        tmp = {{WIDTH{1'b0}}, v};
        return tmp[WIDTH-1:0];
    endfunction

    function automatic logic [31:0] word_to_port(input logic [WIDTH-1:0] w);
        logic [WIDTH+31:0] tmp;
        tmp = {32'd0, w};
        return tmp[31:0];
    endfunction

    function automatic logic [6:0] count_to_port(input logic [CNT_W-1:0] c);
        logic [CNT_W+6:0] tmp;
        tmp = {7'd0, c};
        return tmp[6:0];
    endfunction

endpackage

[design/iiel_cell.sv]
// One storage cell of the list row: holds a single entry and takes its
// neighbour's word on a shift. Depends on iiel_pkg.
module iiel_cell
    import iiel_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] position,
    input  cell_bcast_t      bcast,
    input  logic [WIDTH-1:0] left_word,
    input  logic [WIDTH-1:0] right_word,
    output logic [WIDTH-1:0] word,
    output logic [WIDTH-1:0] read_word
);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (bcast.ins_en)
        begin
            if (position == bcast.pos)
            begin
                word_next = bcast.word;
            end
            else if (position > bcast.pos)
            begin
                word_next = left_word;
            end
        end
        else if (bcast.era_en)
        begin
            if (position >= bcast.pos)
            begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign read_word = (bcast.rd_en && (position == bcast.pos)) ? word_reg : '0;

endmodule

[design/iiel_ctrl.sv]
// Command decoder: checks the index against the count, sets the status and
// the new count, and drives the broadcast to the cell row. Depends on iiel_pkg.
module iiel_ctrl
    import iiel_pkg::*;
(
    input  logic             fire,
    input  logic [1:0]       command,
    input  logic [6:0]       index,
    input  logic [31:0]      value,
    input  logic [CNT_W-1:0] count_cur,
    output cell_bcast_t      bcast,
    output dec_result_t      result
);

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;

    assign idx_ext = CMP_W'(index);
    assign cnt_ext = CMP_W'(count_cur);
    assign full    = (cnt_ext == CMP_W'(DEPTH));

    always_comb
    begin
        result.status     = ST_OK;
        result.count_next = count_cur;
        bcast.ins_en      = 1'b0;
        bcast.era_en      = 1'b0;
        bcast.rd_en       = 1'b0;
        bcast.pos         = idx_ext[IDX_W-1:0];
        bcast.word        = value_to_word(value);
        case (cmd_t'(command))
            CMD_APPEND:
            begin
                // An append is an insert at the current end.
                bcast.pos = cnt_ext[IDX_W-1:0];
                if (full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    bcast.ins_en      = fire;
                    result.count_next = count_cur + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (idx_ext > cnt_ext)
                begin
                    result.status = ST_RANGE;
                end
                else if (full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    bcast.ins_en      = fire;
                    result.count_next = count_cur + CNT_W'(1);
                end
            end
            CMD_ERASE:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    result.status = ST_RANGE;
                end
                else
                begin
                    bcast.era_en      = fire;
                    result.count_next = count_cur - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    result.status = ST_RANGE;
                end
                else
                begin
                    bcast.rd_en = 1'b1;
                end
            end
            default:
            begin
                result.status = ST_RANGE;
            end
        endcase
    end

endmodule

[design/indexed_insert_erase_list_unit.sv]
// Indexed insert/erase list: an ordered list of up to DEPTH words held in a
// row of cells, one entry per cell, with a count of valid entries. Each
// request (append, insert at index, erase at index, read at index) is acted
// on by the whole row at once, which shifts up or down together, so a new
// request can be accepted in every cycle, and the result appears in the
// cycle after acceptance in an output register. A request is held off only
// while that register holds a result the consumer is stalling. The list is
// empty after reset and needs no clearing pass; a bad index or a full list
// is reported in status and leaves the list as it was.
// Depends on iiel_pkg, iiel_ctrl, iiel_cell and assert_macros.svh.
module indexed_insert_erase_list_unit
    import iiel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  command,
    input  logic [6:0]  index,
    input  logic [31:0] value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] read_value,
    output logic [6:0]  count,
    output logic [1:0]  status
);

    logic             req_fire;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [31:0]      read_value_reg;
    logic [6:0]       count_out_reg;
    logic [1:0]       status_reg;
    cell_bcast_t      bcast;
    dec_result_t      dec;
    logic [WIDTH-1:0] cell_word [DEPTH];
    logic [WIDTH-1:0] cell_read [DEPTH];
    logic [WIDTH-1:0] read_word;

    assign req_stall = res_valid_reg && res_stall;
    assign req_fire  = req_valid && !req_stall;

    iiel_ctrl u_ctrl (
        .fire      (req_fire),
        .command   (command),
        .index     (index),
        .value     (value),
        .count_cur (count_reg),
        .bcast     (bcast),
        .result    (dec)
    );

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = cell_word[g];
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = cell_word[g];
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[g+1];
        end

        iiel_cell u_cell (
            .clk        (clk),
            .position   (IDX_W'(g)),
            .bcast      (bcast),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[g]),
            .read_word  (cell_read[g])
        );
    end

    // Only the addressed cell drives a non-zero read word.
    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_word = read_word | cell_read[i];
        end
    end

    assign count_next     = req_fire ? dec.count_next : count_reg;
    assign res_valid_next = req_fire ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            read_value_reg <= word_to_port(read_word);
            count_out_reg  <= count_to_port(dec.count_next);
            status_reg     <= dec.status;
        end
    end

    assign res_valid  = res_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;
    assign status     = status_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count exceeds depth")
    `ASSERT_NEXT(a_error_keeps_count, req_fire && (dec.status != ST_OK),
        count_reg == $past(count_reg), "rejected request changed the count")
    `ASSERT_NEXT(a_append_grows,
        req_fire && (cmd_t'(command) == CMD_APPEND) && (dec.status == ST_OK),
        count_reg == $past(count_reg) + CNT_W'(1), "append did not grow the count")
    `ASSERT_SAME(a_stall_only_when_held, req_stall, res_valid_reg,
        "request stalled with no result waiting")

endmodule

[test/tb_indexed_insert_erase_list_unit.sv]
`timescale 1ns / 100ps
// Self-checking bench for the indexed insert/erase list unit: directed table, then random requests.
// Depends on iiel_pkg and indexed_insert_erase_list_unit; results are checked by a local list mirror.
module tb_indexed_insert_erase_list_unit;
    import iiel_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic [31:0] word;
        logic [6:0]  len;
        status_t     st;
    } list_reply_t;

    typedef struct {
        cmd_t        c;
        logic [6:0]  i;
        logic [31:0] v;
        bit          pinned;
        logic [31:0] rd;
        logic [6:0]  cnt;
        status_t     st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  command;
    logic [6:0]  index;
    logic [31:0] value;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] read_value;
    logic [6:0]  count;
    logic [1:0]  status;

    logic [31:0] mirror_words [DEPTH];
    int          mirror_len;
    list_reply_t pending_replies [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on;
    bit          long_hold_req;
    bit          pin_valid;
    list_reply_t pin_reply;
    bit          growing;
    int          full_extra;
    int          shrink_floor;

    // Rows with pinned set carry results that can be read straight off the list contents.
    stim_row_t directed_rows [25] = '{
        '{CMD_READ,   7'd0,   32'd0,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_ERASE,  7'd0,   32'd0,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_INSERT, 7'd1,   32'd5,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_APPEND, 7'd127, 32'd0,         1'b1, 32'd0,         7'd1, ST_OK},
        '{CMD_INSERT, 7'd0,   32'hFFFFFFFF,  1'b1, 32'd0,         7'd2, ST_OK},
        '{CMD_READ,   7'd0,   32'd0,         1'b1, 32'hFFFFFFFF,  7'd2, ST_OK},
        '{CMD_READ,   7'd1,   32'hFFFFFFFF,  1'b1, 32'd0,         7'd2, ST_OK},
        '{CMD_READ,   7'd2,   32'd0,         1'b1, 32'd0,         7'd2, ST_RANGE},
        '{CMD_READ,   7'd127, 32'd0,         1'b1, 32'd0,         7'd2, ST_RANGE},
        '{CMD_INSERT, 7'd2,   32'h12345678,  1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_INSERT, 7'd1,   32'hA5A5A5A5,  1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_INSERT, 7'd127, 32'hDEADBEEF,  1'b1, 32'd0,         7'd4, ST_RANGE},
        '{CMD_INSERT, 7'd5,   32'd1,         1'b1, 32'd0,         7'd4, ST_RANGE},
        '{CMD_READ,   7'd1,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,   7'd3,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_ERASE,  7'd127, 32'd0,         1'b1, 32'd0,         7'd4, ST_RANGE},
        '{CMD_ERASE,  7'd4,   32'd0,         1'b1, 32'd0,         7'd4, ST_RANGE},
        '{CMD_ERASE,  7'd1,   32'hFFFFFFFF,  1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,   7'd1,   32'hFFFFFFFF,  1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_ERASE,  7'd0,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_APPEND, 7'd64,  32'h80000001,  1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,   7'd64,  32'd0,         1'b1, 32'd0,         7'd3, ST_RANGE},
        '{CMD_ERASE,  7'd2,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,   7'd0,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_ERASE,  7'd0,   32'hFFFFFFFF,  1'b0, 32'd0,         7'd0, ST_OK}
    };

    indexed_insert_erase_list_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .index      (index),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Updates the mirror list for one request and returns the reply it should produce.
    function automatic list_reply_t apply_list_request(input cmd_t c, input logic [6:0] i,
                                                       input logic [31:0] v);
        list_reply_t r;
        int          pos;
        int          k;
        r.word = 32'd0;
        r.st = ST_OK;
        pos = int'(i);
        case (c)
            CMD_APPEND:
            begin
                if (mirror_len >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    mirror_words[mirror_len] = v;
                    mirror_len++;
                end
            end
            CMD_INSERT:
            begin
                if (pos > mirror_len)
                    r.st = ST_RANGE;
                else if (mirror_len >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (k = mirror_len; k > pos; k--)
                        mirror_words[k] = mirror_words[k - 1];
                    mirror_words[pos] = v;
                    mirror_len++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= mirror_len)
                    r.st = ST_RANGE;
                else
                begin
                    for (k = pos; k + 1 < mirror_len; k++)
                        mirror_words[k] = mirror_words[k + 1];
                    mirror_len--;
                end
            end
            default:
            begin
                if (pos >= mirror_len)
                    r.st = ST_RANGE;
                else
                    r.word = mirror_words[pos];
            end
        endcase
        r.len = mirror_len[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : reply_checker
        list_reply_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected, expected none, actual %h %h %h",
                             $time, read_value, count, status);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (read_value !== want.word)
                        report_mismatch("read_value", want.word, read_value);
                    if (count !== want.len)
                        report_mismatch("count", 32'(want.len), 32'(count));
                    if (status !== want.st)
                        report_mismatch("status", 32'(want.st), 32'(status));
                end
            end
            if (req_valid && !req_stall)
            begin
                want = apply_list_request(cmd_t'(command), index, value);
                if (pin_valid)
                    want = pin_reply;
                pending_replies = {pending_replies, want};
            end
        end
    end

    // Result side: random stall bursts, and one long hold-off when asked for.
    initial
    begin : result_side
        int hold_len;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                res_stall <= 1'b1;
                hold_len = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                hold_len = $urandom_range(1, 15);
            end
            else
            begin
                res_stall <= 1'b0;
                hold_len = $urandom_range(1, 12);
            end
            repeat (hold_len - 1) @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic offer_request(input cmd_t c, input logic [6:0] i, input logic [31:0] v,
                                 input bit pinned, input list_reply_t reply);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid <= 1'b1;
        command <= c;
        index <= i;
        value <= v;
        pin_valid = pinned;
        pin_reply = reply;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Alternates between growing the list until it is full and draining it towards empty.
    task automatic pick_request(output cmd_t c, output logic [6:0] i, output logic [31:0] v);
        int r;
        int len;
        len = mirror_len;
        if (growing && len == DEPTH)
        begin
            if (full_extra == 0)
                growing = 1'b0;
            else
                full_extra--;
        end
        else if (!growing && len <= shrink_floor)
        begin
            growing = 1'b1;
            full_extra = $urandom_range(2, 8);
            shrink_floor = $urandom_range(0, 10);
        end
        r = $urandom_range(0, 15);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFFFFFF : $urandom;
        i = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            c = cmd_t'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                i = 7'(len + $urandom_range(0, 1));
        end
        else if (growing ? (r < 45) : (r < 15))
            c = CMD_APPEND;
        else if (growing ? (r < 80) : (r < 25))
        begin
            c = CMD_INSERT;
            i = 7'($urandom_range(0, len));
        end
        else if (growing ? (r < 90) : (r < 40))
        begin
            c = CMD_READ;
            i = (len > 0) ? 7'($urandom_range(0, len - 1)) : 7'd0;
        end
        else
        begin
            c = CMD_ERASE;
            i = (len > 0) ? 7'($urandom_range(0, len - 1)) : 7'd0;
        end
    endtask

    task automatic run_random(input int n, input bit gaps);
        cmd_t        c;
        logic [6:0]  i;
        logic [31:0] v;
        int          k;
        for (k = 0; k < n; k++)
        begin
            if (k % 80 == 0)
                idle_on = gaps && ($urandom_range(0, 3) != 0);
            pick_request(c, i, v);
            offer_request(c, i, v, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : request_side
        list_reply_t reply;
        rst_n = 1'b0;
        req_valid = 1'b0;
        command = CMD_APPEND;
        index = 7'd0;
        value = 32'd0;
        mirror_len = 0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        pin_valid = 1'b0;
        pin_reply = '0;
        growing = 1'b1;
        full_extra = 4;
        shrink_floor = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            reply.word = directed_rows[k].rd;
            reply.len = directed_rows[k].cnt;
            reply.st = directed_rows[k].st;
            offer_request(directed_rows[k].c, directed_rows[k].i, directed_rows[k].v,
                          directed_rows[k].pinned, reply);
        end

        run_random(450, 1'b1);

        // The result side holds off while requests keep coming, so the unit must back up.
        long_hold_req = 1'b1;
        run_random(40, 1'b0);
        wait_drained();

        run_random(650, 1'b1);
        run_random(250, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/iiel_pkg.sv
design/iiel_cell.sv
design/iiel_ctrl.sv
design/indexed_insert_erase_list_unit.sv
test/tb_indexed_insert_erase_list_unit.sv
